[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on i_clk, off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg
// shared types, constants and helper functions of the qrs beat detector
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

    // block geometry
    localparam int WINDOW_LEN = 37;
    localparam int SECTIONS   = 3;
    localparam int WIN_AW     = $clog2(WINDOW_LEN);
    localparam int DLY_AW     = $clog2(2 * SECTIONS);

    // value widths
    localparam int VAL_W   = 48;
    localparam int TOT_W   = 54;
    localparam int SUM_W   = 56;
    localparam int PROD_W  = 58;
    localparam int ACC_W   = 82;
    localparam int RATE_W  = 16;
    localparam int TIME_W  = 32;

    // serial divider geometry
    localparam int DIV_NW   = 60;
    localparam int DIV_DW   = 11;
    localparam int DIV_STEP = 4;
    localparam int DIV_ITER = DIV_NW / DIV_STEP;
    localparam int DIV_CW   = $clog2(DIV_ITER);

    // configuration
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 48;

    typedef enum logic [CFG_IW-1:0] {
        CFG_PERIOD  = 2'd0,
        CFG_REFRACT = 2'd1,
        CFG_FLOOR   = 2'd2
    } t_cfg_idx;

    localparam logic [9:0]       PERIOD_RST  = 10'd4;
    localparam logic [11:0]      REFRACT_RST = 12'd350;
    localparam logic [VAL_W-1:0] FLOOR_RST   = 48'd131072000;

    // arithmetic constants
    localparam logic [VAL_W-1:0]  U48_MAX     = '1;
    localparam logic [ACC_W-1:0]  RND_Q30     = 82'd536870912;
    localparam logic [ACC_W-1:0]  RND_SQ      = 82'd32768;
    localparam logic [ACC_W-1:0]  RND_DECAY   = 82'd1000;
    localparam logic [32:0]       DECAY_MUL   = 33'd1999;
    localparam logic [DIV_DW-1:0] DECAY_DIV   = 11'd2000;
    localparam logic [DIV_DW-1:0] BLEND_DIV   = 11'd10;
    localparam logic [DIV_NW-1:0] RATE_NUM    = 60'd15360000;
    localparam logic [TIME_W-1:0] DELTA_LO    = 32'd250;
    localparam logic [TIME_W-1:0] DELTA_HI    = 32'd2000;

    localparam logic signed [SUM_W-1:0] S48_MAX = 56'sh00_7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] S48_MIN = 56'shFF_8000_0000_0000;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_BQ,
        ST_DIFF,
        ST_SQ,
        ST_WIN,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_DECIDE,
        ST_DECAY,
        ST_DECAY_WAIT,
        ST_RATE,
        ST_RATE_WAIT,
        ST_BLEND,
        ST_BLEND_WAIT,
        ST_DONE
    } t_state;

    // what the shared multiplier is working for
    typedef enum logic [1:0] {
        MM_BQ,
        MM_SQ,
        MM_DECAY
    } t_mul_mode;

    // divider handshake
    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

    // clamp to the signed 48-bit range
    function automatic logic signed [VAL_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > S48_MAX) begin
            r = S48_MAX[VAL_W-1:0];
        end else if (v < S48_MIN) begin
            r = S48_MIN[VAL_W-1:0];
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    // biquad coefficient in q2.30 for a section and a micro-op
    // op order: b0, b1, a1, b2, a2
    function automatic logic signed [31:0] bq_coef(input logic [1:0] sec, input logic [2:0] op);
        logic signed [31:0] c;
        c = 32'sd0;
        case ({sec, op})
            5'b00_000: c = 32'sd1682565;
            5'b00_001: c = 32'sd3365129;
            5'b00_010: c = -32'sd1861399033;
            5'b00_011: c = 32'sd1682565;
            5'b00_100: c = 32'sd832879533;
            5'b01_000: c = 32'sd1073741824;
            5'b01_001: c = 32'sd0;
            5'b01_010: c = -32'sd1844259945;
            5'b01_011: c = -32'sd1073741824;
            5'b01_100: c = 32'sd895367845;
            5'b10_000: c = 32'sd1073741824;
            5'b10_001: c = 32'sh8000_0000;   // minus two in q2.30
            5'b10_010: c = -32'sd2058390328;
            5'b10_011: c = 32'sd1073741824;
            5'b10_100: c = 32'sd1002840200;
            5'b11_000: c = 32'sd1073741824;  // spare section passes through
            default:   c = 32'sd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[design/qrs_div.sv]
// ----------------------------------------------------------------------------
// qrs_div
// unsigned serial divider, four quotient bits per clock
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire qrs_pkg::t_div_req i_req,
    output qrs_pkg::t_div_rsp      o_rsp
);
    import qrs_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW:0]   r_rem;
    logic [DIV_DW-1:0] r_den;

    logic [DIV_NW-1:0] n_num;
    logic [DIV_DW:0]   n_rem;

    always_comb begin
        n_num = r_num;
        n_rem = r_rem;
        for (int k = 0; k < DIV_STEP; k++) begin
            n_rem = {n_rem[DIV_DW-1:0], n_num[DIV_NW-1]};
            n_num = {n_num[DIV_NW-2:0], 1'b0};
            if (n_rem >= {1'b0, r_den}) begin
                n_rem    = n_rem - {1'b0, r_den};
                n_num[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == DIV_CW'(DIV_ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_num;

endmodule

`default_nettype wire

[design/qrs_beat_detector_core.sv]
// ----------------------------------------------------------------------------
// qrs_beat_detector_core
// qrs beat detector: band-pass, difference, square, window mean, threshold
// ----------------------------------------------------------------------------
// One ECG sample goes in per input transaction and one result comes out per
// sample. A small sequencer steps every sample through three biquad sections,
// the squared difference, a 37-sample window mean and the adaptive threshold,
// using one shared 25x33 multiplier and one serial divider (four quotient
// bits per clock); the fifteen filter products all go through that multiplier.
// How long the sequencer stays busy after a sample is taken depends on the
// path: a sample that decays the threshold, a beat without a rate update, or
// a beat that updates a running heart rate, the longest case. Input stall is
// high for that whole time, and longer while a full output register is
// stalled. The finished result sits in an output register, so a new sample is
// taken while it waits. Configuration writes are only legal while the block is
// idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qrs_beat_detector_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [qrs_pkg::CFG_IW-1:0]     i_cfg_index,
    input  wire logic [qrs_pkg::CFG_DW-1:0]     i_cfg_data,
    // sample channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [11:0]                    i_raw_sample,
    // result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [qrs_pkg::VAL_W-1:0]           o_integrated_level,
    output logic [qrs_pkg::VAL_W-1:0]           o_beat_threshold,
    output logic                                o_beat_found,
    output logic [qrs_pkg::RATE_W-1:0]          o_heart_rate
);
    import qrs_pkg::*;

    // configuration registers
    logic [9:0]       r_period;
    logic [11:0]      r_refract;
    logic [VAL_W-1:0] r_floor;

    // sequencer
    t_state    r_state, n_state;
    t_mul_mode r_mode;
    logic [1:0] r_ph;
    logic [1:0] r_sec;
    logic [2:0] r_op;

    // shared multiplier
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    // filter state
    logic signed [VAL_W-1:0] r_w [0:2*SECTIONS-1];
    logic signed [VAL_W-1:0] r_x;
    logic signed [VAL_W-1:0] r_y;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [VAL_W-1:0] r_last;

    // square and window
    logic [31:0]        r_mag;
    logic [VAL_W-1:0]   r_sq;
    logic [VAL_W-1:0]   r_win_mem [0:WINDOW_LEN-1];
    logic [WINDOW_LEN-1:0] r_win_vld;
    logic [VAL_W-1:0]   r_win_rd;
    logic               r_win_rdv;
    logic [WIN_AW-1:0]  r_pos;
    logic [TOT_W-1:0]   r_total;
    logic [VAL_W-1:0]   r_mean;

    // detection state
    logic [VAL_W-1:0]  r_thr;
    logic [RATE_W-1:0] r_rate;
    logic [RATE_W-1:0] r_inst;
    logic [TIME_W-1:0] r_time;
    logic [TIME_W-1:0] r_lastbeat;
    logic [DIV_DW-1:0] r_delta;
    logic              r_seen;
    logic              r_beat;

    // output register
    logic              r_out_vld;
    logic [VAL_W-1:0]  r_o_level;
    logic [VAL_W-1:0]  r_o_thr;
    logic              r_o_beat;
    logic [RATE_W-1:0] r_o_rate;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic in_acc;
    logic out_load;

    // multiplier operands
    logic signed [VAL_W-1:0]  bq_src;
    logic signed [31:0]       coef;
    logic signed [48:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [24:0]       mul_half;
    logic [ACC_W-1:0]         mul_rnd;

    // biquad apply
    logic                     w_sel;
    logic [DLY_AW-1:0]        w_idx;
    logic signed [VAL_W-1:0]  w_rd;
    logic signed [51:0]       m_q30;
    logic signed [SUM_W-1:0]  m_ext;
    logic signed [SUM_W-1:0]  w_ext;

    // difference and decision
    logic signed [VAL_W:0]    diff;
    logic [VAL_W:0]           diff_mag;
    logic [VAL_W-1:0]         win_old;
    logic [TIME_W-1:0]        elapsed;
    logic                     out_refract;
    logic                     is_beat;
    logic                     rate_ok;
    logic [VAL_W+3:0]         thr_blend;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // operand selection for the shared multiplier
    always_comb begin
        bq_src = ((r_op == 3'd2) || (r_op == 3'd4)) ? r_y : r_x;
        coef   = bq_coef(r_sec, r_op);
        case (r_mode)
            MM_BQ: begin
                mul_a   = {bq_src[VAL_W-1], bq_src};
                mul_b   = {coef[31], coef};
                mul_rnd = RND_Q30;
            end
            MM_SQ: begin
                mul_a   = {17'd0, r_mag};
                mul_b   = {1'b0, r_mag};
                mul_rnd = RND_SQ;
            end
            MM_DECAY: begin
                mul_a   = {1'b0, r_thr};
                mul_b   = DECAY_MUL;
                mul_rnd = RND_DECAY;
            end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                mul_rnd = '0;
            end
        endcase
        // low half first, unsigned, then the signed high half
        mul_half = (r_ph == 2'd0) ? $signed({1'b0, mul_a[23:0]}) : mul_a[48:24];
    end

    // biquad delay access: b0 reads w0, b1 reads w1, a1 writes w0, a2 writes w1
    assign w_sel = (r_op == 3'd1) || (r_op == 3'd4);
    assign w_idx = DLY_AW'({r_sec, w_sel});
    assign w_rd  = r_w[w_idx];
    assign m_q30 = r_acc[ACC_W-1:30];
    assign m_ext = {{(SUM_W-52){m_q30[51]}}, m_q30};
    assign w_ext = {{(SUM_W-VAL_W){w_rd[VAL_W-1]}}, w_rd};

    assign diff     = {r_x[VAL_W-1], r_x} - {r_last[VAL_W-1], r_last};
    assign diff_mag = diff[VAL_W] ? (VAL_W+1)'(0) - diff : diff;

    assign win_old = r_win_rdv ? r_win_rd : '0;

    assign elapsed     = r_time - r_lastbeat;
    assign out_refract = elapsed >= {20'd0, r_refract};
    assign is_beat     = r_mean > r_thr;
    assign rate_ok     = r_seen && (elapsed > DELTA_LO) && (elapsed < DELTA_HI);
    assign thr_blend   = {4'd0, r_mean} + {1'b0, r_thr, 3'd0} - {4'd0, r_thr} + 52'd4;

    // next state and divider requests
    always_comb begin
        n_state     = r_state;
        div_req     = '0;
        out_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_ph == 2'd2) begin
                    case (r_mode)
                        MM_BQ:    n_state = ST_BQ;
                        MM_SQ:    n_state = ST_SQ;
                        MM_DECAY: n_state = ST_DECAY;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_BQ: begin
                if ((r_op == 3'd4) && (r_sec == 2'(SECTIONS - 1))) begin
                    n_state = ST_DIFF;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DIFF: begin
                n_state = (diff_mag[VAL_W:32] != '0) ? ST_WIN : ST_MUL;
            end
            ST_SQ: begin
                n_state = ST_WIN;
            end
            ST_WIN: begin
                n_state = ST_MEAN;
            end
            ST_MEAN: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(r_total) + DIV_NW'(WINDOW_LEN / 2);
                div_req.den   = DIV_DW'(WINDOW_LEN);
                n_state       = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!out_refract) begin
                    n_state = ST_DONE;
                end else if (is_beat) begin
                    n_state = rate_ok ? ST_RATE : ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DECAY: begin
                div_req.start = 1'b1;
                div_req.num   = r_acc[DIV_NW-1:0];
                div_req.den   = DECAY_DIV;
                n_state       = ST_DECAY_WAIT;
            end
            ST_DECAY_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_RATE: begin
                div_req.start = 1'b1;
                div_req.num   = RATE_NUM + DIV_NW'(r_delta >> 1);
                div_req.den   = r_delta;
                n_state       = ST_RATE_WAIT;
            end
            ST_RATE_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_rate == '0) ? ST_DONE : ST_BLEND;
                end
            end
            ST_BLEND: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'({r_rate, 3'd0}) + DIV_NW'(r_rate)
                              + DIV_NW'(r_inst) + DIV_NW'(5);
                div_req.den   = BLEND_DIV;
                n_state       = ST_BLEND_WAIT;
            end
            ST_BLEND_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hand over once the output register is free
                if (!r_out_vld || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= PERIOD_RST;
            r_refract <= REFRACT_RST;
            r_floor   <= FLOOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PERIOD:  r_period  <= i_cfg_data[9:0];
                CFG_REFRACT: r_refract <= i_cfg_data[11:0];
                CFG_FLOOR:   r_floor   <= i_cfg_data[VAL_W-1:0];
                default:     ;
            endcase
        end
    end

    // sequencer counters and the other state that reset clears, apart from the configuration and r_state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MM_BQ;
            r_ph       <= '0;
            r_sec      <= '0;
            r_op       <= '0;
            for (int i = 0; i < 2 * SECTIONS; i++) begin
                r_w[i] <= '0;
            end
            r_last     <= '0;
            r_win_vld  <= '0;
            r_pos      <= '0;
            r_total    <= '0;
            r_thr      <= FLOOR_RST;
            r_rate     <= '0;
            r_time     <= '0;
            r_lastbeat <= '0;
            r_seen     <= 1'b0;
            r_beat     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_mode <= MM_BQ;
                        r_ph   <= '0;
                        r_sec  <= '0;
                        r_op   <= '0;
                        r_beat <= 1'b0;
                    end
                end
                ST_MUL: begin
                    r_ph <= (r_ph == 2'd2) ? 2'd0 : r_ph + 2'd1;
                end
                ST_BQ: begin
                    case (r_op)
                        3'd2:    r_w[w_idx] <= sat48(r_sum - m_ext);
                        3'd4:    r_w[w_idx] <= sat48(r_sum - m_ext);
                        default: ;
                    endcase
                    if (r_op == 3'd4) begin
                        r_op  <= '0;
                        r_sec <= r_sec + 2'd1;
                    end else begin
                        r_op <= r_op + 3'd1;
                    end
                end
                ST_DIFF: begin
                    r_last <= r_x;
                    r_mode <= MM_SQ;
                end
                ST_WIN: begin
                    r_total          <= r_total - TOT_W'(win_old) + TOT_W'(r_sq);
                    r_win_vld[r_pos] <= 1'b1;
                    r_pos  <= (r_pos == WIN_AW'(WINDOW_LEN - 1)) ? '0 : r_pos + 1'b1;
                    r_time <= r_time + TIME_W'(r_period);
                end
                ST_DECIDE: begin
                    if (out_refract && is_beat) begin
                        r_beat     <= 1'b1;
                        r_thr      <= thr_blend[VAL_W+2:3];
                        r_lastbeat <= r_time;
                        r_seen     <= 1'b1;
                    end else if (out_refract) begin
                        r_mode <= MM_DECAY;
                    end
                end
                ST_DECAY_WAIT: begin
                    if (div_rsp.done) begin
                        r_thr <= (div_rsp.quo < DIV_NW'(r_floor)) ? r_floor
                                                                  : div_rsp.quo[VAL_W-1:0];
                    end
                end
                ST_RATE_WAIT: begin
                    if (div_rsp.done && (r_rate == '0)) begin
                        r_rate <= div_rsp.quo[RATE_W-1:0];
                    end
                end
                ST_BLEND_WAIT: begin
                    if (div_rsp.done) begin
                        r_rate <= div_rsp.quo[RATE_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers with no reset value
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_x <= $signed({20'd0, i_raw_sample, 16'd0});
                end
            end
            ST_MUL: begin
                case (r_ph)
                    2'd0: begin
                        r_prod <= PROD_W'(mul_half * mul_b);
                    end
                    2'd1: begin
                        r_acc  <= $signed({{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod} + mul_rnd);
                        r_prod <= PROD_W'(mul_half * mul_b);
                    end
                    default: begin
                        r_acc <= r_acc + $signed({r_prod, 24'd0});
                    end
                endcase
            end
            ST_BQ: begin
                case (r_op)
                    3'd0:    r_y   <= sat48(m_ext + w_ext);
                    3'd1:    r_sum <= m_ext + w_ext;
                    3'd3:    r_sum <= m_ext;
                    3'd4:    r_x   <= r_y;
                    default: ;
                endcase
            end
            ST_DIFF: begin
                r_mag <= diff_mag[31:0];
                r_sq  <= U48_MAX;
            end
            ST_SQ: begin
                r_sq <= (r_acc[ACC_W-1:64] != '0) ? U48_MAX : r_acc[63:16];
            end
            ST_MEAN_WAIT: begin
                if (div_rsp.done) begin
                    r_mean <= (div_rsp.quo[DIV_NW-1:VAL_W] != '0) ? U48_MAX
                                                                 : div_rsp.quo[VAL_W-1:0];
                end
            end
            ST_DECIDE: begin
                r_delta <= elapsed[DIV_DW-1:0];
            end
            ST_RATE_WAIT: begin
                if (div_rsp.done) begin
                    r_inst <= div_rsp.quo[RATE_W-1:0];
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_o_level <= r_mean;
            r_o_thr   <= r_thr;
            r_o_beat  <= r_beat;
            r_o_rate  <= r_rate;
        end
    end

    // window memory, registered read at the current slot
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WIN) begin
            r_win_mem[r_pos] <= r_sq;
        end
        r_win_rd  <= r_win_mem[r_pos];
        r_win_rdv <= r_win_vld[r_pos];
    end

    qrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_out_valid        = r_out_vld;
    assign o_integrated_level = r_o_level;
    assign o_beat_threshold   = r_o_thr;
    assign o_beat_found       = r_o_beat;
    assign o_heart_rate       = r_o_rate;

    `QRS_ASSERT_NOW(a_pos_range, 1'b1, r_pos <= WIN_AW'(WINDOW_LEN - 1), "window slot out of range")
    `QRS_ASSERT_NOW(a_sec_range, r_state == ST_BQ, r_sec <= 2'(SECTIONS - 1), "section out of range")
    `QRS_ASSERT_NOW(a_div_done, div_rsp.done,
        r_state == ST_MEAN_WAIT || r_state == ST_DECAY_WAIT ||
        r_state == ST_RATE_WAIT || r_state == ST_BLEND_WAIT, "divider done with nobody waiting")
    `QRS_ASSERT_NEXT(a_out_load, out_load, r_out_vld && (r_state == ST_IDLE), "result not presented")

endmodule

`default_nettype wire
